@@ rtl/lrre_pkg.sv @@
// ----------------------------------------------------------------------------
// lrre_pkg
// shared word types and mode codes of the light ramp run encoder
// ----------------------------------------------------------------------------
package lrre_pkg;

  localparam int NUM_CH   = 4;
  localparam int LVL_W    = 4;
  localparam int CNT_W    = 16;
  localparam int NUM_SLOT = 2 * NUM_CH;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_EQUAL = 2'd1;
  localparam logic [1:0] MODE_ASC   = 2'd2;
  localparam logic [1:0] MODE_DESC  = 2'd3;

  typedef struct packed {
    logic [15:0] voxel_word;
    logic        final_voxel;
  } lrre_in_t;

  typedef struct packed {
    logic [1:0]       channel;
    logic [LVL_W-1:0] run_start;
    logic [LVL_W-1:0] run_end;
    logic [CNT_W-1:0] run_length;
    logic             closing_run;
    logic             last;
  } lrre_out_t;

endpackage

@@ rtl/light_ramp_run_encoder_core.sv @@
// ----------------------------------------------------------------------------
// light_ramp_run_encoder_core
// run coder for four 4-bit light channels of a voxel light word
//
// in_valid/in_ready/in_word carry one voxel per word; out_valid/out_ready/
// out_word carry one run per word, tagged with its channel. cfg_we with
// cfg_wdata writes the channel enable mask; the user must do so only while
// the block is idle, the block does not enforce it. Channel state is updated
// in the cycle a voxel is accepted; the runs it causes (0 to 8) go into a
// result bank and leave through the output register.
// Throughput: one voxel per cycle while each voxel causes at most one run
// and the receiver does not stall; otherwise the next voxel waits while the
// single output register drains the bank one run per cycle when not stalled.
// The next voxel is accepted in the cycle the bank's last run moves into
// the output register, so a waiting result does not block the input.
// When the receiver stalls the output register holds its word and the
// bank stops draining; in_ready drops while more than one run, or one that cannot move out, is banked.
// Reset (synchronous, rst_n low) clears all run state, enables all
// channels and starts a new volume at the next voxel.
// ----------------------------------------------------------------------------
module light_ramp_run_encoder_core
  import lrre_pkg::*;
#(
  parameter int VOLUME = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lrre_in_t        in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output lrre_out_t       out_word,
  input  logic            cfg_we,
  input  logic [NUM_CH-1:0] cfg_wdata
);

  localparam logic [CNT_W-1:0] VOL_MAX = CNT_W'(VOLUME);

  // channel state
  logic [LVL_W-1:0] first_r [NUM_CH];
  logic [LVL_W-1:0] lastl_r [NUM_CH];
  logic [CNT_W-1:0] count_r [NUM_CH];
  logic [LVL_W-1:0] prev_r  [NUM_CH];
  logic [1:0]       mode_r  [NUM_CH];
  logic             await_r;
  logic [NUM_CH-1:0] enable_r;

  logic [LVL_W-1:0] first_nxt [NUM_CH];
  logic [LVL_W-1:0] lastl_nxt [NUM_CH];
  logic [CNT_W-1:0] count_nxt [NUM_CH];
  logic [1:0]       mode_nxt  [NUM_CH];

  // result bank
  logic [NUM_SLOT-1:0] pend_r;
  lrre_out_t           bank_r   [NUM_SLOT];
  logic [NUM_SLOT-1:0] mask_nxt;
  lrre_out_t           bank_nxt [NUM_SLOT];

  logic      out_valid_r;
  lrre_out_t out_word_r;

  logic                        in_fire;
  logic                        pop;
  logic [NUM_SLOT-1:0]         sel;
  logic [$clog2(NUM_SLOT)-1:0] sel_idx;
  logic [NUM_SLOT-1:0]         pend_left;
  lrre_out_t                   pop_word;

  assign pop      = (pend_r != '0) && (!out_valid_r || out_ready);
  assign in_ready = (pend_r == '0) || ($onehot(pend_r) && pop);
  assign in_fire  = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // per channel run update and result slots
  always_comb begin
    logic [LVL_W-1:0] lvl;
    logic             eq;
    logic             up;
    logic             down;
    logic             ext;
    logic [1:0]       mode_new;
    for (int c = 0; c < NUM_CH; c++) begin
      lvl  = in_word.voxel_word[c*LVL_W +: LVL_W];
      eq   = (lvl == prev_r[c]);
      up   = ({1'b0, lvl} == {1'b0, prev_r[c]} + 5'd1);
      down = ({1'b0, lvl} + 5'd1 == {1'b0, prev_r[c]});
      mode_new = mode_r[c];
      unique case (mode_r[c])
        MODE_NONE: begin
          ext      = eq || up || down;
          mode_new = eq ? MODE_EQUAL : (up ? MODE_ASC : MODE_DESC);
        end
        MODE_EQUAL: ext = eq;
        MODE_ASC:   ext = up;
        MODE_DESC:  ext = down;
        default:    ext = 1'b0;
      endcase

      bank_nxt[c].channel     = 2'(c);
      bank_nxt[c].run_start   = first_r[c];
      bank_nxt[c].run_end     = lastl_r[c];
      bank_nxt[c].run_length  = count_r[c];
      bank_nxt[c].closing_run = 1'b0;
      bank_nxt[c].last        = 1'b0;

      if (!await_r && ext && (count_r[c] < VOL_MAX)) begin
        first_nxt[c]   = first_r[c];
        lastl_nxt[c]   = lvl;
        count_nxt[c]   = count_r[c] + CNT_W'(1);
        mode_nxt[c]    = mode_new;
        mask_nxt[c]    = 1'b0;
      end else begin
        first_nxt[c]   = lvl;
        lastl_nxt[c]   = lvl;
        count_nxt[c]   = CNT_W'(1);
        mode_nxt[c]    = MODE_NONE;
        mask_nxt[c]    = !await_r && enable_r[c];
      end

      bank_nxt[NUM_CH+c].channel     = 2'(c);
      bank_nxt[NUM_CH+c].run_start   = first_nxt[c];
      bank_nxt[NUM_CH+c].run_end     = lastl_nxt[c];
      bank_nxt[NUM_CH+c].run_length  = count_nxt[c];
      bank_nxt[NUM_CH+c].closing_run = 1'b1;
      bank_nxt[NUM_CH+c].last        = 1'b0;
      mask_nxt[NUM_CH+c]             = in_word.final_voxel && enable_r[c];
    end
  end

  // lowest pending slot goes out next
  always_comb begin
    logic found;
    found   = 1'b0;
    sel     = '0;
    sel_idx = '0;
    for (int i = 0; i < NUM_SLOT; i++) begin
      if (!found && pend_r[i]) begin
        found   = 1'b1;
        sel[i]  = 1'b1;
        sel_idx = ($clog2(NUM_SLOT))'(i);
      end
    end
    pend_left     = pend_r & ~sel;
    pop_word      = bank_r[sel_idx];
    pop_word.last = (pend_left == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r     <= 1'b1;
      enable_r    <= '1;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        first_r[c] <= '0;
        lastl_r[c] <= '0;
        count_r[c] <= '0;
        prev_r[c]  <= '0;
        mode_r[c]  <= MODE_NONE;
      end
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        pend_r  <= mask_nxt;
        await_r <= in_word.final_voxel;
        for (int c = 0; c < NUM_CH; c++) begin
          first_r[c] <= first_nxt[c];
          lastl_r[c] <= lastl_nxt[c];
          count_r[c] <= count_nxt[c];
          prev_r[c]  <= in_word.voxel_word[c*LVL_W +: LVL_W];
          mode_r[c]  <= mode_nxt[c];
        end
      end else if (pop) begin
        pend_r <= pend_left;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < NUM_SLOT; i++) begin
        bank_r[i] <= bank_nxt[i];
      end
    end
    if (pop) begin
      out_word_r <= pop_word;
    end
  end

  // no new word while more than one run, or one that cannot leave, is banked
  a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (pend_r == '0) || ($onehot(pend_r) && pop))
    else $error("word accepted with runs still banked");

  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_word.final_voxel) |=> await_r)
    else $error("final voxel did not restart the volume");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.run_length != '0))
    else $error("zero length run on output");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[0] <= VOL_MAX) && (count_r[1] <= VOL_MAX) &&
    (count_r[2] <= VOL_MAX) && (count_r[3] <= VOL_MAX))
    else $error("run longer than the volume");

endmodule
